### hdl/assert_macros.svh
// Assertion helpers for checker files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMPLIES(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("assertion failed");

// Next-cycle implication.
`define ASSERT_NEXT(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("assertion failed");

`endif

### hdl/scta_pkg.sv
`default_nettype none
package scta_pkg;

   localparam int FIFO_DEPTH = 256;
   localparam int PTR_W      = $clog2(FIFO_DEPTH);
   localparam int CHAR_W     = 7;
   localparam int KEY_W      = 7;

   localparam logic OP_SCAN = 1'b0;
   localparam logic OP_READ = 1'b1;

   localparam logic [KEY_W-1:0] SC_LSHIFT = 7'h2A;
   localparam logic [KEY_W-1:0] SC_RSHIFT = 7'h36;
   localparam logic [KEY_W-1:0] SC_CAPS   = 7'h3A;
   localparam logic [KEY_W-1:0] SC_LCTRL  = 7'h1D;
   localparam logic [KEY_W-1:0] SC_LALT   = 7'h38;

   localparam int MF_SHIFT = 0;
   localparam int MF_CAPS  = 1;
   localparam int MF_CTRL  = 2;
   localparam int MF_ALT   = 3;

   localparam logic [CHAR_W-1:0] CASE_OFS = 7'd32;

   typedef logic [3:0] flags_type;

   typedef struct packed {
      logic      pop;
      logic      key_available;
      flags_type flags;
      logic      overflow;
   } stage_type;

   function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
      if (p == PTR_W'(FIFO_DEPTH - 1)) return '0;
      else return p + 1'b1;
   endfunction

   function automatic logic is_lower(input logic [CHAR_W-1:0] c);
      return (c >= 7'h61) && (c <= 7'h7A);
   endfunction

   function automatic logic is_upper(input logic [CHAR_W-1:0] c);
      return (c >= 7'h41) && (c <= 7'h5A);
   endfunction

   // US layout, unshifted
   function automatic logic [CHAR_W-1:0] plain_char(input logic [KEY_W-1:0] k);
      logic [CHAR_W-1:0] c;
      case (k)
         7'h02: c = 7'h31;  7'h03: c = 7'h32;  7'h04: c = 7'h33;  7'h05: c = 7'h34;
         7'h06: c = 7'h35;  7'h07: c = 7'h36;  7'h08: c = 7'h37;  7'h09: c = 7'h38;
         7'h0A: c = 7'h39;  7'h0B: c = 7'h30;  7'h0C: c = 7'h2D;  7'h0D: c = 7'h3D;
         7'h0E: c = 7'h08;  7'h0F: c = 7'h09;
         7'h10: c = 7'h71;  7'h11: c = 7'h77;  7'h12: c = 7'h65;  7'h13: c = 7'h72;
         7'h14: c = 7'h74;  7'h15: c = 7'h79;  7'h16: c = 7'h75;  7'h17: c = 7'h69;
         7'h18: c = 7'h6F;  7'h19: c = 7'h70;  7'h1A: c = 7'h5B;  7'h1B: c = 7'h5D;
         7'h1C: c = 7'h0A;  7'h1E: c = 7'h61;  7'h1F: c = 7'h73;
         7'h20: c = 7'h64;  7'h21: c = 7'h66;  7'h22: c = 7'h67;  7'h23: c = 7'h68;
         7'h24: c = 7'h6A;  7'h25: c = 7'h6B;  7'h26: c = 7'h6C;  7'h27: c = 7'h3B;
         7'h28: c = 7'h27;  7'h29: c = 7'h60;  7'h2B: c = 7'h5C;  7'h2C: c = 7'h7A;
         7'h2D: c = 7'h78;  7'h2E: c = 7'h63;  7'h2F: c = 7'h76;
         7'h30: c = 7'h62;  7'h31: c = 7'h6E;  7'h32: c = 7'h6D;  7'h33: c = 7'h2C;
         7'h34: c = 7'h2E;  7'h35: c = 7'h2F;  7'h37: c = 7'h2A;  7'h39: c = 7'h20;
         7'h47: c = 7'h37;  7'h48: c = 7'h38;  7'h49: c = 7'h39;  7'h4A: c = 7'h2D;
         7'h4B: c = 7'h34;  7'h4C: c = 7'h35;  7'h4D: c = 7'h36;  7'h4E: c = 7'h2B;
         7'h4F: c = 7'h31;  7'h50: c = 7'h32;  7'h51: c = 7'h33;  7'h52: c = 7'h30;
         7'h53: c = 7'h2E;
         default: c = '0;
      endcase
      return c;
   endfunction

   // US layout, shifted; letters fold to upper case, keypad unchanged
   function automatic logic [CHAR_W-1:0] shifted_char(input logic [KEY_W-1:0] k);
      logic [CHAR_W-1:0] c;
      logic [CHAR_W-1:0] p;
      p = plain_char(k);
      case (k)
         7'h02: c = 7'h21;  7'h03: c = 7'h40;  7'h04: c = 7'h23;  7'h05: c = 7'h24;
         7'h06: c = 7'h25;  7'h07: c = 7'h5E;  7'h08: c = 7'h26;  7'h09: c = 7'h2A;
         7'h0A: c = 7'h28;  7'h0B: c = 7'h29;  7'h0C: c = 7'h5F;  7'h0D: c = 7'h2B;
         7'h1A: c = 7'h7B;  7'h1B: c = 7'h7D;  7'h27: c = 7'h3A;  7'h28: c = 7'h22;
         7'h29: c = 7'h7E;  7'h2B: c = 7'h7C;  7'h33: c = 7'h3C;  7'h34: c = 7'h3E;
         7'h35: c = 7'h3F;
         default: c = is_lower(p) ? p - CASE_OFS : p;
      endcase
      return c;
   endfunction

endpackage
`default_nettype wire

### hdl/scancode_to_ascii_fifo.sv
// channel | direction | fields
// req     | in        | operation, scancode
// rsp     | out       | char_valid, char_code, key_available, modifier flags, overflow
//
// One word accepted per cycle unless req_stall is high; its response passes through stage 1
// (state update and character RAM access), then the output register.
// Synchronous reset clears pointers, modifier flags and the pipeline; RAM is not cleared.
// rsp_stall holds the output register; req_stall rises only when both stages are full and rsp_stall is high.
`default_nettype none
module scancode_to_ascii_fifo (
   input  wire                             clock,
   input  wire                             reset,
   input  wire                             req_valid,
   output logic                            req_stall,
   input  wire                             req_operation,
   input  wire  [7:0]                      req_scancode,
   output logic                            rsp_valid,
   input  wire                             rsp_stall,
   output logic                            rsp_char_valid,
   output logic [scta_pkg::CHAR_W-1:0]     rsp_char_code,
   output logic                            rsp_key_available,
   output logic                            rsp_shift_held,
   output logic                            rsp_caps_on,
   output logic                            rsp_ctrl_held,
   output logic                            rsp_alt_held,
   output logic                            rsp_overflow
);
   import scta_pkg::*;

   logic [CHAR_W-1:0] mem [FIFO_DEPTH];
   logic [CHAR_W-1:0] rdata_ff;

   logic [PTR_W-1:0]  wp_ff, wp_in, rp_ff, rp_in;
   flags_type         flags_ff, flags_in;
   logic              s1_valid_ff, s1_valid_in;
   stage_type         s1_ff, s1_in;
   logic              out_valid_ff, out_valid_in;
   stage_type         out_ff;
   logic [CHAR_W-1:0] out_code_ff;

   logic              accept, s1_go;
   logic [KEY_W-1:0]  key;
   logic              released, is_read, is_mod;
   logic              pop, push, push_try, full;
   logic [CHAR_W-1:0] ch;

   assign s1_go     = !out_valid_ff || !rsp_stall;
   assign req_stall = s1_valid_ff && !s1_go;
   assign accept    = req_valid && !req_stall;

   assign key      = req_scancode[KEY_W-1:0];
   assign released = req_scancode[7];
   assign is_read  = (req_operation == OP_READ);
   assign full     = (ptr_next(wp_ff) == rp_ff);

   always_comb begin
      flags_in = flags_ff;
      is_mod   = 1'b1;
      case (key) inside
         SC_LSHIFT, SC_RSHIFT: flags_in[MF_SHIFT] = !released;
         SC_LCTRL:             flags_in[MF_CTRL]  = !released;
         SC_LALT:              flags_in[MF_ALT]   = !released;
         SC_CAPS:              flags_in[MF_CAPS]  = flags_ff[MF_CAPS] ^ !released;
         default:              is_mod = 1'b0;
      endcase
      if (is_read) flags_in = flags_ff;
   end

   always_comb begin
      ch = flags_ff[MF_SHIFT] ? shifted_char(key) : plain_char(key);
      if (flags_ff[MF_CAPS]) begin
         if (flags_ff[MF_SHIFT] && is_upper(ch)) ch = ch + CASE_OFS;
         else if (!flags_ff[MF_SHIFT] && is_lower(ch)) ch = ch - CASE_OFS;
      end
   end

   assign push_try = !is_read && !is_mod && !released && (ch != '0);
   assign push     = push_try && !full;
   assign pop      = is_read && (wp_ff != rp_ff);
   assign wp_in    = push ? ptr_next(wp_ff) : wp_ff;
   assign rp_in    = pop ? ptr_next(rp_ff) : rp_ff;

   always_comb begin
      s1_in.pop           = pop;
      s1_in.key_available = (wp_in != rp_in);
      s1_in.flags         = flags_in;
      s1_in.overflow      = push_try && full;
   end

   assign s1_valid_in  = accept ? 1'b1 : (s1_go ? 1'b0 : s1_valid_ff);
   assign out_valid_in = s1_go ? s1_valid_ff : out_valid_ff;

   // one op per word, so a write and a read never hit the same entry in one cycle
   always_ff @(posedge clock) begin
      if (accept && push) mem[wp_ff] <= ch;
      if (accept && pop) rdata_ff <= mem[rp_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff        <= '0;
         rp_ff        <= '0;
         flags_ff     <= '0;
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (accept) begin
            wp_ff    <= wp_in;
            rp_ff    <= rp_in;
            flags_ff <= flags_in;
         end
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) s1_ff <= s1_in;
      if (s1_go && s1_valid_ff) begin
         out_ff      <= s1_ff;
         out_code_ff <= s1_ff.pop ? rdata_ff : '0;
      end
   end

   assign rsp_valid         = out_valid_ff;
   assign rsp_char_valid    = out_ff.pop;
   assign rsp_char_code     = out_code_ff;
   assign rsp_key_available = out_ff.key_available;
   assign rsp_shift_held    = out_ff.flags[MF_SHIFT];
   assign rsp_caps_on       = out_ff.flags[MF_CAPS];
   assign rsp_ctrl_held     = out_ff.flags[MF_CTRL];
   assign rsp_alt_held      = out_ff.flags[MF_ALT];
   assign rsp_overflow      = out_ff.overflow;

endmodule
`default_nettype wire

### hdl/scta_checker.sv
`default_nettype none
`include "assert_macros.svh"
module scta_checker (
   input wire                         clock,
   input wire                         reset,
   input wire                         rsp_valid,
   input wire                         rsp_stall,
   input wire                         rsp_char_valid,
   input wire [scta_pkg::CHAR_W-1:0]  rsp_char_code,
   input wire                         rsp_key_available,
   input wire                         rsp_overflow
);
   import scta_pkg::*;

   `ASSERT_IMPLIES(a_code_zero, clock, reset, rsp_valid && !rsp_char_valid, rsp_char_code == '0)
   `ASSERT_IMPLIES(a_code_nonzero, clock, reset, rsp_valid && rsp_char_valid, rsp_char_code != '0)
   `ASSERT_IMPLIES(a_ovf_not_read, clock, reset, rsp_valid && rsp_overflow, !rsp_char_valid)
   `ASSERT_IMPLIES(a_ovf_has_data, clock, reset, rsp_valid && rsp_overflow, rsp_key_available)
   `ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid)

endmodule

bind scancode_to_ascii_fifo scta_checker u_scta_checker (
   .clock             (clock),
   .reset             (reset),
   .rsp_valid         (rsp_valid),
   .rsp_stall         (rsp_stall),
   .rsp_char_valid    (rsp_char_valid),
   .rsp_char_code     (rsp_char_code),
   .rsp_key_available (rsp_key_available),
   .rsp_overflow      (rsp_overflow)
);
`default_nettype wire

### tb/scancode_to_ascii_fifo_tb.sv
module scancode_to_ascii_fifo_tb;
   import scta_pkg::*;

   localparam int IDLE_LIMIT = 3000;
   localparam int HOLD_CYCLES = 400;

   // US set-1 tables, keys 0x00..0x53; everything above maps to zero
   localparam logic [CHAR_W-1:0] PLAIN_MAP [84] = '{
      7'h00, 7'h00, 7'h31, 7'h32, 7'h33, 7'h34, 7'h35, 7'h36,
      7'h37, 7'h38, 7'h39, 7'h30, 7'h2D, 7'h3D, 7'h08, 7'h09,
      7'h71, 7'h77, 7'h65, 7'h72, 7'h74, 7'h79, 7'h75, 7'h69,
      7'h6F, 7'h70, 7'h5B, 7'h5D, 7'h0A, 7'h00, 7'h61, 7'h73,
      7'h64, 7'h66, 7'h67, 7'h68, 7'h6A, 7'h6B, 7'h6C, 7'h3B,
      7'h27, 7'h60, 7'h00, 7'h5C, 7'h7A, 7'h78, 7'h63, 7'h76,
      7'h62, 7'h6E, 7'h6D, 7'h2C, 7'h2E, 7'h2F, 7'h00, 7'h2A,
      7'h00, 7'h20, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00,
      7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h37,
      7'h38, 7'h39, 7'h2D, 7'h34, 7'h35, 7'h36, 7'h2B, 7'h31,
      7'h32, 7'h33, 7'h30, 7'h2E
   };

   localparam logic [CHAR_W-1:0] SHIFT_MAP [84] = '{
      7'h00, 7'h00, 7'h21, 7'h40, 7'h23, 7'h24, 7'h25, 7'h5E,
      7'h26, 7'h2A, 7'h28, 7'h29, 7'h5F, 7'h2B, 7'h08, 7'h09,
      7'h51, 7'h57, 7'h45, 7'h52, 7'h54, 7'h59, 7'h55, 7'h49,
      7'h4F, 7'h50, 7'h7B, 7'h7D, 7'h0A, 7'h00, 7'h41, 7'h53,
      7'h44, 7'h46, 7'h47, 7'h48, 7'h4A, 7'h4B, 7'h4C, 7'h3A,
      7'h22, 7'h7E, 7'h00, 7'h7C, 7'h5A, 7'h58, 7'h43, 7'h56,
      7'h42, 7'h4E, 7'h4D, 7'h3C, 7'h3E, 7'h3F, 7'h00, 7'h2A,
      7'h00, 7'h20, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00,
      7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h37,
      7'h38, 7'h39, 7'h2D, 7'h34, 7'h35, 7'h36, 7'h2B, 7'h31,
      7'h32, 7'h33, 7'h30, 7'h2E
   };

   // opening words: {operation, scancode}
   localparam logic [8:0] OPENING [26] = '{
      {OP_READ, 8'hFF}, {OP_SCAN, 8'h1E}, {OP_SCAN, 8'h2A}, {OP_SCAN, 8'h1E},
      {OP_SCAN, 8'hAA}, {OP_SCAN, 8'h36}, {OP_SCAN, 8'h02}, {OP_SCAN, 8'hB6},
      {OP_SCAN, 8'h3A}, {OP_SCAN, 8'hBA}, {OP_SCAN, 8'h10}, {OP_SCAN, 8'h2A},
      {OP_SCAN, 8'h10}, {OP_SCAN, 8'h02}, {OP_SCAN, 8'hAA}, {OP_SCAN, 8'h3A},
      {OP_SCAN, 8'h1D}, {OP_SCAN, 8'h38}, {OP_SCAN, 8'h1E}, {OP_SCAN, 8'h9D},
      {OP_SCAN, 8'hB8}, {OP_SCAN, 8'h00}, {OP_SCAN, 8'h7F}, {OP_SCAN, 8'h9E},
      {OP_SCAN, 8'hFF}, {OP_READ, 8'h00}
   };

   typedef struct packed {
      logic              char_valid;
      logic [CHAR_W-1:0] char_code;
      logic              key_available;
      logic              shift_held;
      logic              caps_on;
      logic              ctrl_held;
      logic              alt_held;
      logic              overflow;
   } key_rsp_type;

   class keymap_board;
      key_rsp_type       due_words[$];
      logic [CHAR_W-1:0] typed_chars[$];
      flags_type         mods;
      int                errors;
      int                words;
      int                pops;
      int                drops;

      function new();
         mods = '0;
         errors = 0;
         words = 0;
         pops = 0;
         drops = 0;
      endfunction

      function logic [CHAR_W-1:0] decode_key(input logic [KEY_W-1:0] key);
         logic [CHAR_W-1:0] c;
         if (key > 7'd83) c = '0;
         else c = mods[MF_SHIFT] ? SHIFT_MAP[key] : PLAIN_MAP[key];
         if (mods[MF_CAPS]) begin
            if (mods[MF_SHIFT] && c >= 7'h41 && c <= 7'h5A) c = c + CASE_OFS;
            else if (!mods[MF_SHIFT] && c >= 7'h61 && c <= 7'h7A) c = c - CASE_OFS;
         end
         return c;
      endfunction

      function void take_req(input logic op, input logic [7:0] sc);
         key_rsp_type       r;
         logic [KEY_W-1:0]  key;
         logic [CHAR_W-1:0] c;
         logic              rel;
         r = '0;
         words++;
         rel = sc[7];
         key = sc[6:0];
         if (op == OP_READ) begin
            if (typed_chars.size() != 0) begin
               r.char_valid = 1'b1;
               r.char_code = typed_chars.pop_front();
               pops++;
            end
         end else if (key == SC_LSHIFT || key == SC_RSHIFT) begin
            mods[MF_SHIFT] = !rel;
         end else if (key == SC_LCTRL) begin
            mods[MF_CTRL] = !rel;
         end else if (key == SC_LALT) begin
            mods[MF_ALT] = !rel;
         end else if (key == SC_CAPS) begin
            if (!rel) mods[MF_CAPS] = !mods[MF_CAPS];
         end else if (!rel) begin
            c = decode_key(key);
            if (c != '0) begin
               if (typed_chars.size() == FIFO_DEPTH - 1) begin
                  r.overflow = 1'b1;
                  drops++;
               end else begin
                  typed_chars.push_back(c);
               end
            end
         end
         r.key_available = typed_chars.size() != 0;
         r.shift_held = mods[MF_SHIFT];
         r.caps_on = mods[MF_CAPS];
         r.ctrl_held = mods[MF_CTRL];
         r.alt_held = mods[MF_ALT];
         due_words.push_back(r);
      endfunction

      function void check_field(input string name, input int want, input int got);
         if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            errors++;
         end
      endfunction

      function void match_rsp(input key_rsp_type got);
         key_rsp_type want;
         if (due_words.size() == 0) begin
            $error("response word with nothing pending");
            errors++;
            return;
         end
         want = due_words.pop_front();
         check_field("char_valid", want.char_valid, got.char_valid);
         check_field("char_code", want.char_code, got.char_code);
         check_field("key_available", want.key_available, got.key_available);
         check_field("shift_held", want.shift_held, got.shift_held);
         check_field("caps_on", want.caps_on, got.caps_on);
         check_field("ctrl_held", want.ctrl_held, got.ctrl_held);
         check_field("alt_held", want.alt_held, got.alt_held);
         check_field("overflow", want.overflow, got.overflow);
      endfunction
   endclass

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_operation = OP_SCAN;
   logic [7:0]        req_scancode = 8'h00;
   logic              rsp_stall = 1'b0;
   logic              req_stall;
   logic              rsp_valid;
   logic              rsp_char_valid;
   logic [CHAR_W-1:0] rsp_char_code;
   logic              rsp_key_available;
   logic              rsp_shift_held;
   logic              rsp_caps_on;
   logic              rsp_ctrl_held;
   logic              rsp_alt_held;
   logic              rsp_overflow;

   logic              calm = 1'b0;
   logic              hold_req = 1'b0;
   int                hold_left = 0;
   int                idle_cycles = 0;
   keymap_board       board = new();

   scancode_to_ascii_fifo dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_operation     (req_operation),
      .req_scancode      (req_scancode),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_char_valid    (rsp_char_valid),
      .rsp_char_code     (rsp_char_code),
      .rsp_key_available (rsp_key_available),
      .rsp_shift_held    (rsp_shift_held),
      .rsp_caps_on       (rsp_caps_on),
      .rsp_ctrl_held     (rsp_ctrl_held),
      .rsp_alt_held      (rsp_alt_held),
      .rsp_overflow      (rsp_overflow)
   );

   always #2 clock = ~clock;

   // monitor, scoreboard feed and watchdog
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall) board.take_req(req_operation, req_scancode);
         if (rsp_valid && !rsp_stall) begin
            board.match_rsp('{char_valid: rsp_char_valid, char_code: rsp_char_code,
                              key_available: rsp_key_available,
                              shift_held: rsp_shift_held, caps_on: rsp_caps_on,
                              ctrl_held: rsp_ctrl_held, alt_held: rsp_alt_held,
                              overflow: rsp_overflow});
         end
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) idle_cycles = 0;
         else idle_cycles++;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("timeout: no word moved for %0d cycles", IDLE_LIMIT);
            $display("Verification failed");
            $finish;
         end
      end
   end

   // receiver back-pressure
   initial begin
      forever begin
         @(posedge clock);
         if (hold_req && hold_left == 0) begin
            hold_left = HOLD_CYCLES;
            hold_req = 1'b0;
         end
         if (hold_left > 0) begin
            rsp_stall <= 1'b1;
            hold_left--;
         end else if (calm) begin
            rsp_stall <= 1'b0;
         end else begin
            rsp_stall <= ($urandom_range(99) < 17);
         end
      end
   end

   task automatic send_word(input logic op, input logic [7:0] sc);
      if (!calm) begin
         while ($urandom_range(99) < 17) begin
            req_valid <= 1'b0;
            @(posedge clock);
         end
      end
      req_valid <= 1'b1;
      req_operation <= op;
      req_scancode <= sc;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   task automatic press_release(input logic [7:0] key, input bit release_it);
      send_word(OP_SCAN, key);
      if (release_it) send_word(OP_SCAN, key | 8'h80);
   endtask

   // keystroke-shaped traffic with frequent reads
   task automatic type_words(input int n);
      int         pick;
      logic [7:0] k;
      repeat (n) begin
         pick = $urandom_range(99);
         if (pick < 35) begin
            k = 8'($urandom_range(8'h53));
            press_release(k, $urandom_range(3) != 0);
         end else if (pick < 45) begin
            k = $urandom_range(1) ? {1'b0, SC_LSHIFT} : {1'b0, SC_RSHIFT};
            k[7] = 1'($urandom_range(1));
            send_word(OP_SCAN, k);
         end else if (pick < 52) begin
            k = $urandom_range(1) ? {1'b0, SC_LCTRL} : {1'b0, SC_LALT};
            k[7] = 1'($urandom_range(1));
            send_word(OP_SCAN, k);
         end else if (pick < 56) begin
            press_release({1'b0, SC_CAPS}, 1'b1);
         end else begin
            send_word(OP_READ, 8'($urandom_range(255)));
         end
      end
   endtask

   // fill past capacity, then drain past empty
   task automatic fill_and_drain(input int n);
      logic [7:0] k;
      repeat (n) begin
         k = $urandom_range(1) ? 8'(8'h02 + $urandom_range(11))
                               : 8'(8'h10 + $urandom_range(11));
         send_word(OP_SCAN, k);
      end
      repeat (n) send_word(OP_READ, 8'($urandom_range(255)));
   endtask

   task automatic noise_words(input int n);
      repeat (n) send_word(1'($urandom_range(1)), 8'($urandom_range(255)));
   endtask

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (OPENING[i]) send_word(OPENING[i][8], OPENING[i][7:0]);

      type_words(300);
      hold_req = 1'b1;
      fill_and_drain(300);
      calm = 1'b1;
      type_words(120);
      calm = 1'b0;
      noise_words(300);
      type_words(200);
      req_valid <= 1'b0;

      while (board.due_words.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);

      $display("%0d words checked: %0d characters read back, %0d dropped on a full queue",
               board.words, board.pops, board.drops);
      if (board.errors == 0 && board.due_words.size() == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
